@@ hw/rtl/atwg_pkg.sv @@
// Shared widths, register codes and control structs of the triangle wave generator.
`default_nettype none

package atwg_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int AMP_W      = 31;
  localparam int PERIOD_W   = 24;
  localparam int DUTY_W     = 17;
  localparam int DFRAC_W    = 16;
  localparam int PHASE_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int TICK_UNITS = 256;

  localparam int PROD_W     = DFRAC_W + PERIOD_W;
  localparam int NEXT_W     = PHASE_W + 1;
  localparam int QUO_W      = 32;
  localparam int FRAC_W     = QUO_W + 1;
  localparam int MAG_W      = AMP_W + 1;
  localparam int SUM_W      = SAMPLE_W + 3;
  localparam int CNT_W      = 6;
  localparam int MOD_STEPS  = NEXT_W;
  localparam int FRAC_STEPS = QUO_W;

  localparam logic [DUTY_W-1:0]  DUTY_RESET = DUTY_W'(32768);
  localparam logic [DFRAC_W-1:0] DUTY_HALF  = DFRAC_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_DUTY      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic mod_start;
    logic t_from_div;
    logic mul;
    logic setup;
    logic frac_full;
    logic frac_start;
    logic frac_take;
    logic scale;
    logic out_write;
    logic bypass;
    logic phase_direct;
    logic wrap_start;
    logic phase_from_div;
  } dp_cmd_t;

  typedef struct packed {
    logic period_zero;
    logic phase_lt_p;
    logic div_done;
    logic num_eq_den;
    logic next_fits;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/atwg_ifs.sv @@
// Stream and configuration channel interfaces of the triangle wave generator.
`default_nettype none

interface atwg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [atwg_pkg::SAMPLE_W-1:0] base_sample;
  modport source (output valid, output base_sample, input ready);
  modport sink (input valid, input base_sample, output ready);
endinterface

interface atwg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [atwg_pkg::SAMPLE_W-1:0] out_sample;
  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

interface atwg_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [atwg_pkg::CFG_IDX_W-1:0]       index;
  logic [atwg_pkg::SAMPLE_W-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/asymmetric_triangle_wave_generator_core.sv @@
// Top level of the asymmetric triangle wave generator added to a base signal.
//
//   Channel  Dir  Payload           Beat taken when
//   cfg      in   index, data       valid && ready (ready is always high)
//   base     in   base_sample       valid && ready
//   result   out  out_sample        valid && ready
//
// Between input beats a sample normally passes through the 32-step serial divider that
// forms the phase fraction. With the period at zero the triangle and phase update are skipped.
// After a period change the phase may first need a 25-step reduction, and a period below
// one tick can add a 25-step phase wrap after the result.
// Reset is synchronous and needs no clearing pass. A stalled result holds in its output
// register while the next beat may already be taken; that sample then waits to be written.
`default_nettype none

module asymmetric_triangle_wave_generator_core (
  input  wire logic  clk,
  input  wire logic  rst,
  atwg_cfg_if.sink   cfg,
  atwg_in_if.sink    base,
  atwg_out_if.source result
);
  import atwg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  atwg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (base.valid),
    .in_ready  (base.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  atwg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .in_sample  (base.base_sample),
    .cmd        (cmd),
    .status     (status),
    .out_sample (result.out_sample)
  );

endmodule

`default_nettype wire

@@ hw/rtl/atwg_div.sv @@
// Serial restoring divider shared by the phase reduction, the phase wrap and the fraction.
`default_nettype none

module atwg_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [atwg_pkg::CNT_W-1:0]    steps,
  input  wire logic [atwg_pkg::PROD_W-1:0]   rem_init,
  input  wire logic [atwg_pkg::QUO_W-1:0]    sh_init,
  input  wire logic [atwg_pkg::PROD_W-1:0]   den_in,
  output logic                               done,
  output logic [atwg_pkg::PROD_W-1:0]        rem,
  output logic [atwg_pkg::QUO_W-1:0]         quo
);
  import atwg_pkg::*;

  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] den;
  logic [QUO_W-1:0]  sh;
  logic [PROD_W:0]   rem_sh;
  logic [PROD_W:0]   diff;
  logic              take;

  assign rem_sh = {rem, sh[QUO_W-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign take   = rem_sh >= {1'b0, den};
  assign done   = (cnt == '0);
  assign quo    = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      sh  <= sh_init;
      den <= den_in;
    end else if (cnt != '0) begin
      rem <= take ? diff[PROD_W-1:0] : rem_sh[PROD_W-1:0];
      sh  <= {sh[QUO_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/atwg_dp.sv @@
// Datapath: configuration registers, phase, triangle arithmetic and output register.
`default_nettype none

module atwg_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [atwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [atwg_pkg::SAMPLE_W-1:0] cfg_data,
  input  wire logic [atwg_pkg::SAMPLE_W-1:0] in_sample,
  input  wire atwg_pkg::dp_cmd_t             cmd,
  output atwg_pkg::dp_status_t               status,
  output logic [atwg_pkg::SAMPLE_W-1:0]      out_sample
);
  import atwg_pkg::*;

  logic [AMP_W-1:0]    amplitude;
  logic [PERIOD_W-1:0] period;
  logic [DUTY_W-1:0]   duty;
  logic [PHASE_W-1:0]  phase;

  logic [SAMPLE_W-1:0] base;
  logic [PHASE_W-1:0]  t;
  logic [PROD_W-1:0]   peak;
  logic [PROD_W-1:0]   num;
  logic [PROD_W-1:0]   den;
  logic                rising;
  logic [FRAC_W-1:0]   frac;
  logic [MAG_W-1:0]    prod;

  logic [DFRAC_W-1:0]  duty_eff;
  logic [PROD_W-1:0]   ts;
  logic [PROD_W-1:0]   whole;
  logic                rising_c;
  logic [MAG_W-1:0]    a2;
  logic [MAG_W-1:0]    mag;
  logic [2*QUO_W-1:0]  mult;
  logic [SUM_W-1:0]    a_ext;
  logic [SUM_W-1:0]    p_ext;
  logic [SUM_W-1:0]    e;
  logic [SUM_W-1:0]    tri_val;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] sat;
  logic [NEXT_W-1:0]   next_s;
  logic [NEXT_W-1:0]   next_sub;
  logic                next_lt;
  logic                sub_lt;

  logic                div_start;
  logic [CNT_W-1:0]    div_steps;
  logic [PROD_W-1:0]   div_rem_init;
  logic [QUO_W-1:0]    div_sh_init;
  logic [PROD_W-1:0]   div_den;
  logic                div_done;
  logic [PROD_W-1:0]   div_rem;
  logic [QUO_W-1:0]    div_quo;

  assign duty_eff = (duty[DUTY_W-1] || (duty[DFRAC_W-1:0] == '0)) ? DUTY_HALF
                                                                 : duty[DFRAC_W-1:0];
  assign ts       = {t, DFRAC_W'(0)};
  assign whole    = {period, DFRAC_W'(0)};
  assign rising_c = ts <= peak;

  assign a2   = {amplitude, 1'b0};
  assign mag  = a2[MAG_W-1] ? (~a2 + MAG_W'(1)) : a2;
  assign mult = (2*QUO_W)'(mag) * (2*QUO_W)'(frac[QUO_W-1:0]);

  assign a_ext   = {{(SUM_W-AMP_W){amplitude[AMP_W-1]}}, amplitude};
  assign p_ext   = {{(SUM_W-MAG_W){1'b0}}, prod};
  assign e       = amplitude[AMP_W-1] ? (~p_ext + SUM_W'(1)) : p_ext;
  assign tri_val = cmd.bypass ? '0 : (rising ? (e - a_ext) : (a_ext - e));
  assign sum     = {{(SUM_W-SAMPLE_W){base[SAMPLE_W-1]}}, base} + tri_val;

  always_comb begin
    if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
      sat = sum[SAMPLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign next_s   = {1'b0, t} + NEXT_W'(TICK_UNITS);
  assign next_sub = next_s - {1'b0, period};
  assign next_lt  = next_s < {1'b0, period};
  assign sub_lt   = next_sub < {1'b0, period};

  assign status.period_zero = (period == '0);
  assign status.phase_lt_p  = phase < period;
  assign status.div_done    = div_done;
  assign status.num_eq_den  = (num == den);
  assign status.next_fits   = next_lt || sub_lt;

  always_comb begin
    div_start    = cmd.mod_start || cmd.wrap_start || cmd.frac_start;
    div_steps    = CNT_W'(MOD_STEPS);
    div_rem_init = '0;
    div_den      = {{(PROD_W-PERIOD_W){1'b0}}, period};
    div_sh_init  = {{1'b0, phase}, {(QUO_W-NEXT_W){1'b0}}};
    if (cmd.wrap_start) begin
      div_sh_init = {next_s, {(QUO_W-NEXT_W){1'b0}}};
    end else if (cmd.frac_start) begin
      div_steps    = CNT_W'(FRAC_STEPS);
      div_rem_init = num;
      div_sh_init  = '0;
      div_den      = den;
    end
  end

  atwg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .sh_init  (div_sh_init),
    .den_in   (div_den),
    .done     (div_done),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= '0;
      period    <= '0;
      duty      <= DUTY_RESET;
      phase     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AMPLITUDE: amplitude <= cfg_data[AMP_W-1:0];
          REG_PERIOD:    period    <= cfg_data[PERIOD_W-1:0];
          REG_DUTY:      duty      <= cfg_data[DUTY_W-1:0];
          default:       ;
        endcase
      end
      if (cmd.phase_direct) begin
        phase <= next_lt ? next_s[PHASE_W-1:0] : next_sub[PHASE_W-1:0];
      end else if (cmd.phase_from_div) begin
        phase <= div_rem[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      base <= in_sample;
      t    <= phase;
    end
    if (cmd.t_from_div) begin
      t <= div_rem[PHASE_W-1:0];
    end
    if (cmd.mul) begin
      peak <= PROD_W'(duty_eff) * PROD_W'(period);
    end
    if (cmd.setup) begin
      rising <= rising_c;
      num    <= rising_c ? ts : (ts - peak);
      den    <= rising_c ? peak : (whole - peak);
    end
    if (cmd.frac_full) begin
      frac <= {1'b1, {QUO_W{1'b0}}};
    end else if (cmd.frac_take) begin
      frac <= {1'b0, div_quo};
    end
    if (cmd.scale) begin
      prod <= frac[QUO_W] ? mag : mult[2*QUO_W-1:QUO_W];
    end
    if (cmd.out_write) begin
      out_sample <= sat;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/atwg_ctrl.sv @@
// Controller state machine that sequences the datapath for one sample.
`default_nettype none

module atwg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire atwg_pkg::dp_status_t status,
  output atwg_pkg::dp_cmd_t         cmd
);
  import atwg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SETUP,
    S_FSTART,
    S_FRAC,
    S_SCALE,
    S_SUM,
    S_PHASE,
    S_WRAP
  } state_t;

  state_t state;
  logic   bypass;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.bypass = bypass;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          cmd.mod_start = !status.period_zero && !status.phase_lt_p;
        end
      end
      S_REDUCE: cmd.t_from_div = status.div_done;
      S_MUL:    cmd.mul        = 1'b1;
      S_SETUP:  cmd.setup      = 1'b1;
      S_FSTART: begin
        cmd.frac_full  = status.num_eq_den;
        cmd.frac_start = !status.num_eq_den;
      end
      S_FRAC:   cmd.frac_take  = status.div_done;
      S_SCALE:  cmd.scale      = 1'b1;
      S_SUM:    cmd.out_write  = out_free;
      S_PHASE: begin
        cmd.phase_direct = status.next_fits;
        cmd.wrap_start   = !status.next_fits;
      end
      S_WRAP:   cmd.phase_from_div = status.div_done;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bypass    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_SUM) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            bypass <= status.period_zero;
            if (status.period_zero) begin
              state <= S_SUM;
            end else if (status.phase_lt_p) begin
              state <= S_MUL;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: if (status.div_done) state <= S_MUL;
        S_MUL:    state <= S_SETUP;
        S_SETUP:  state <= S_FSTART;
        S_FSTART: state <= status.num_eq_den ? S_SCALE : S_FRAC;
        S_FRAC:   if (status.div_done) state <= S_SCALE;
        S_SCALE:  state <= S_SUM;
        S_SUM: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= bypass ? S_IDLE : S_PHASE;
          end
        end
        S_PHASE:  state <= status.next_fits ? S_IDLE : S_WRAP;
        S_WRAP:   if (status.div_done) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/atwg_checker.sv @@
// Port-level assertions for the triangle wave generator and their binding.
`default_nettype none

module atwg_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [atwg_pkg::SAMPLE_W-1:0] out_sample,
  input wire logic                          cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("Stalled result changed or vanished.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("Input taken again or result produced without any work.");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> cfg_ready)
    else $error("Configuration channel closed.");

endmodule

bind asymmetric_triangle_wave_generator_core atwg_checker u_atwg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (base.valid),
  .in_ready   (base.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_sample (result.out_sample),
  .cfg_ready  (cfg.ready)
);

`default_nettype wire
